// ----- sv/mees_pkg.sv -----
// Package for the exception and event scheduler: item and result payload types,
// controller command and status structs, and fixed constants.
// No dependencies.
`default_nettype none
package mees_pkg;

	localparam int unsigned FIRED_W = 13;

	localparam logic [1:0] KIND_SCHEDULE = 2'd0;
	localparam logic [1:0] KIND_TEST     = 2'd1;
	localparam logic [1:0] KIND_RAISE    = 2'd2;

	localparam logic [31:0] STATUS_BEV_MASK = 32'h0040_0000;
	localparam logic [31:0] VEC_BOOT        = 32'hbfc0_0180;
	localparam logic [31:0] VEC_NORMAL      = 32'h8000_0080;
	localparam logic [31:0] VEC_COP_OFFSET  = 32'h0000_0040;
	localparam logic [31:0] CAUSE_BD        = 32'h8000_0000;
	localparam logic [31:0] CAUSE_INTERRUPT = 32'h0000_0400;
	localparam logic [31:0] STATUS_IE_IM2   = 32'h0000_0401;
	localparam logic [7:0]  GTE_OPCODE      = 8'h4a;
	localparam logic [7:0]  GTE_OPCODE_MASK = 8'hfe;
	localparam logic [31:0] EPC_DELAY_STEP  = 32'h0000_0004;
	localparam logic [63:0] DIST_MAX        = 64'h7fff_ffff_ffff_ffff;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  event_index;
		logic [63:0] time_value;
		logic [10:0] irq_status;
		logic [10:0] irq_mask;
		logic [31:0] current_status;
		logic [31:0] current_pc;
		logic [31:0] next_instruction;
		logic [30:0] cause_value;
		logic        in_delay_slot;
		logic        cop_vector;
	} item_t;

	typedef struct packed {
		logic [FIRED_W-1:0] fired_events;
		logic               exception_taken;
		logic [31:0]        new_pc;
		logic [31:0]        new_epc;
		logic [31:0]        new_cause;
		logic [31:0]        new_status;
		logic [63:0]        next_due;
	} result_t;

	typedef struct packed {
		logic load;
		logic sched_write;
		logic scan_start;
		logic scan_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_sched;
		logic scan_needed;
		logic scan_last;
		logic out_free;
	} ctrl_sts_t;

endpackage
`default_nettype wire

// ----- sv/mips_exception_and_event_scheduler.sv -----
// Top level of the exception and event scheduler.
// Depends on mees_pkg, mees_ctrl and mees_dp.
//
// Items enter on the item channel (item_valid, item_stall, item) and results
// leave on the result channel (result_valid, result_stall, result); a transfer
// happens on a rising edge where valid is high and stall is low. Every item
// gives exactly one result.
// A schedule item, a raise item or a test item that finds nothing to scan is
// executed in the EXEC state after its transfer and loaded into the result
// register in the WRITE state, which waits while result_stall holds the
// previous result.
// A test item whose earliest due target has passed walks the event table
// through its single read port, one event per cycle; its scan runs through the
// SCAN and LAST states before WRITE loads the result register.
// item_stall stays high from the transfer until the result register is loaded,
// so the next item may enter while a result still waits to be taken.
// While result_stall holds a finished result, the block keeps it stable and
// the item in progress waits before loading the result register.
// Reset clears the pending mask, the earliest due target and all handshake
// state; the scan reads every event table entry but compares only pending ones.
`default_nettype none
module mips_exception_and_event_scheduler
	import mees_pkg::*;
#(
	parameter int unsigned NUM_EVENTS = 13
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	mees_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mees_dp #(
		.NUM_EVENTS(NUM_EVENTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.sts         (sts),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule
`default_nettype wire

// ----- sv/mees_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mees_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 13,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/mees_ctrl.sv -----
// Controller state machine of the exception and event scheduler.
// Depends on mees_pkg for the command and status structs.
`default_nettype none
module mees_ctrl
	import mees_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_stall,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_LAST,
		ST_WRITE
	} state_t;

	state_t state_q;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.load = item_valid;
			ST_EXEC: begin
				cmd.sched_write = sts.is_sched;
				cmd.scan_start  = !sts.is_sched && sts.scan_needed;
			end
			ST_SCAN:  cmd.scan_step = 1'b1;
			ST_LAST:  cmd = '0;
			ST_WRITE: cmd.finish = sts.out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (!sts.is_sched && sts.scan_needed) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST:  state_q <= ST_WRITE;
				ST_WRITE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/mees_dp.sv -----
// Datapath of the exception and event scheduler: item register, event table,
// pending mask, scan comparator, exception entry logic and result register.
// Depends on mees_pkg and mees_ram.
`default_nettype none
module mees_dp
	import mees_pkg::*;
#(
	parameter int unsigned NUM_EVENTS = 13
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire item_t     item,
	input  wire ctrl_cmd_t cmd,
	output ctrl_sts_t      sts,
	output logic           result_valid,
	input  wire logic      result_stall,
	output result_t        result
);

	localparam int unsigned AW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_EVENTS - 1);

	item_t                 item_q;
	logic [NUM_EVENTS-1:0] pending_q;
	logic [NUM_EVENTS-1:0] fired_q;
	logic [63:0]           earliest_due_q;
	logic [63:0]           best_dist_q;
	logic [63:0]           best_target_q;
	logic                  scan_run_q;
	logic [AW-1:0]         scan_idx_q;
	logic                  cmp_valid_s1;
	logic [AW-1:0]         cmp_idx_s1;
	logic                  result_valid_q;
	result_t               result_q;

	logic [63:0]           target_rd;
	logic [63:0]           delta;
	logic                  dist_pos;
	logic                  idx_ok;
	logic [NUM_EVENTS-1:0] sched_bit;
	logic [NUM_EVENTS-1:0] cmp_bit;
	logic                  cmp_pending;
	logic                  irq_take;
	logic                  take;
	logic                  bd;
	logic [31:0]           code;
	logic [31:0]           vec;
	logic [63:0]           next_due;
	result_t               result_d;

	assign idx_ok    = 32'(item_q.event_index) < NUM_EVENTS;
	assign sched_bit = NUM_EVENTS'(1) << item_q.event_index;
	assign cmp_bit   = NUM_EVENTS'(1) << cmp_idx_s1;
	assign cmp_pending = |(pending_q & cmp_bit);

	mees_ram #(
		.WIDTH(64),
		.DEPTH(NUM_EVENTS)
	) u_targets (
		.clk  (clk),
		.we   (cmd.sched_write && idx_ok),
		.waddr(AW'(item_q.event_index)),
		.wdata(item_q.time_value),
		.raddr(scan_idx_q),
		.rdata(target_rd)
	);

	assign delta    = target_rd - item_q.time_value;
	assign dist_pos = (delta != 64'd0) && !delta[63];

	assign sts.is_sched    = (item_q.kind == KIND_SCHEDULE);
	assign sts.scan_needed = (item_q.kind == KIND_TEST) && (pending_q != '0)
		&& (earliest_due_q < item_q.time_value);
	assign sts.scan_last   = (scan_idx_q == LAST_IDX);
	assign sts.out_free    = !result_valid_q || !result_stall;

	always_comb begin
		irq_take = (|(item_q.irq_status & item_q.irq_mask))
			&& ((item_q.current_status & STATUS_IE_IM2) == STATUS_IE_IM2)
			&& ((item_q.next_instruction[31:24] & GTE_OPCODE_MASK) != GTE_OPCODE);
		take = (item_q.kind == KIND_RAISE) || ((item_q.kind == KIND_TEST) && irq_take);
		bd   = (item_q.kind == KIND_RAISE) && item_q.in_delay_slot;
		code = (item_q.kind == KIND_RAISE) ? {1'b0, item_q.cause_value} : CAUSE_INTERRUPT;
		vec  = ((item_q.current_status & STATUS_BEV_MASK) != '0) ? VEC_BOOT : VEC_NORMAL;
		if ((item_q.kind == KIND_RAISE) && item_q.cop_vector) begin
			vec = vec - VEC_COP_OFFSET;
		end
		next_due = scan_run_q ? best_target_q : earliest_due_q;

		result_d.fired_events    = FIRED_W'(fired_q);
		result_d.exception_taken = take;
		result_d.next_due        = next_due;
		if (take) begin
			result_d.new_pc     = vec;
			result_d.new_epc    = bd ? (item_q.current_pc - EPC_DELAY_STEP)
				: item_q.current_pc;
			result_d.new_cause  = bd ? (code | CAUSE_BD) : code;
			result_d.new_status = {item_q.current_status[31:6],
				item_q.current_status[3:0], 2'b00};
		end else begin
			result_d.new_pc     = item_q.current_pc;
			result_d.new_epc    = '0;
			result_d.new_cause  = '0;
			result_d.new_status = item_q.current_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= '0;
			earliest_due_q <= '0;
			scan_run_q     <= 1'b0;
			scan_idx_q     <= '0;
			cmp_valid_s1   <= 1'b0;
			cmp_idx_s1     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			cmp_valid_s1 <= cmd.scan_step;
			if (cmd.scan_step) begin
				cmp_idx_s1 <= scan_idx_q;
			end
			if (cmd.load) begin
				scan_run_q <= 1'b0;
			end
			if (cmd.scan_start) begin
				scan_run_q <= 1'b1;
				scan_idx_q <= '0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + AW'(1);
			end
			if (cmd.sched_write && idx_ok) begin
				pending_q <= pending_q | sched_bit;
			end else if (cmp_valid_s1 && cmp_pending && !dist_pos) begin
				pending_q <= pending_q & ~cmp_bit;
			end
			if (cmd.finish && scan_run_q) begin
				earliest_due_q <= best_target_q;
			end
			if (cmd.finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= item;
			fired_q <= '0;
		end
		if (cmd.scan_start) begin
			best_dist_q   <= DIST_MAX;
			best_target_q <= item_q.time_value;
		end
		if (cmp_valid_s1 && cmp_pending) begin
			if (dist_pos) begin
				if (best_dist_q > delta) begin
					best_dist_q   <= delta;
					best_target_q <= target_rd;
				end
			end else begin
				fired_q <= fired_q | cmp_bit;
			end
		end
		if (cmd.finish) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ----- bench/tb_mips_exception_and_event_scheduler.sv -----
// Self-checking testbench for the exception and event scheduler.
// It predicts each result with its own model of the event table and the exception entry.
// Depends on mees_pkg and mips_exception_and_event_scheduler.
`timescale 1ns / 1ps
module tb_mips_exception_and_event_scheduler;
	import mees_pkg::*;

	localparam int unsigned NUM_EV       = FIRED_W;
	localparam logic [1:0]  KIND_UNUSED  = 2'd3;
	localparam logic [31:0] KU_IE_FIELD  = 32'h0000_003f;
	localparam logic [31:0] KU_IE_OLD    = 32'h0000_000f;
	localparam int          CYCLE_LIMIT  = 250000;
	localparam int          DRAIN_CYCLES = 24;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item_bus     = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_bus;

	logic [NUM_EV-1:0] ev_pending  = '0;
	logic [63:0]       ev_target [NUM_EV];
	logic [63:0]       ev_earliest = '0;

	result_t    outcome_fifo [16];
	logic [3:0] exp_wr_ptr      = '0;
	logic [3:0] exp_rd_ptr      = '0;
	int         mismatches      = 0;
	int         items_sent      = 0;
	int         results_checked = 0;
	int         fired_results   = 0;
	int         taken_results   = 0;
	int         cycle_count     = 0;
	int         rx_hold         = 0;
	bit         tx_steady       = 1'b0;
	bit         rx_steady       = 1'b0;

	mips_exception_and_event_scheduler #(
		.NUM_EVENTS(NUM_EV)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void apply_exception(inout result_t r, input logic [31:0] code,
			input logic bd, input logic cop, input item_t it);
		logic [31:0] vec;
		r.new_epc = it.current_pc;
		if (bd) begin
			code = code | CAUSE_BD;
			r.new_epc = it.current_pc - EPC_DELAY_STEP;
		end
		vec = ((it.current_status & STATUS_BEV_MASK) != '0) ? VEC_BOOT : VEC_NORMAL;
		if (cop)
			vec = vec - VEC_COP_OFFSET;
		r.exception_taken = 1'b1;
		r.new_pc = vec;
		r.new_cause = code;
		r.new_status = (it.current_status & ~KU_IE_FIELD) | ((it.current_status & KU_IE_OLD) << 2);
	endfunction

	function automatic result_t compute_outcome(input item_t it);
		result_t           r;
		logic [63:0]       delta;
		logic [63:0]       best_dist;
		logic [63:0]       best_tgt;
		logic [NUM_EV-1:0] fired;
		fired = '0;
		r.exception_taken = 1'b0;
		r.new_pc = it.current_pc;
		r.new_epc = '0;
		r.new_cause = '0;
		r.new_status = it.current_status;
		case (it.kind)
			KIND_SCHEDULE: begin
				if (it.event_index < NUM_EV) begin
					ev_target[it.event_index] = it.time_value;
					ev_pending[it.event_index] = 1'b1;
				end
			end
			KIND_TEST: begin
				if (ev_pending != '0 && ev_earliest < it.time_value) begin
					best_dist = DIST_MAX;
					best_tgt = it.time_value;
					for (int i = 0; i < NUM_EV; i++) begin
						if (ev_pending[i]) begin
							delta = ev_target[i] - it.time_value;
							if (delta != '0 && !delta[63]) begin
								if (best_dist > delta) begin
									best_dist = delta;
									best_tgt = ev_target[i];
								end
							end else begin
								ev_pending[i] = 1'b0;
								fired[i] = 1'b1;
							end
						end
					end
					ev_earliest = best_tgt;
				end
				if ((it.irq_status & it.irq_mask) != '0 &&
						(it.current_status & STATUS_IE_IM2) == STATUS_IE_IM2 &&
						(it.next_instruction[31:24] & GTE_OPCODE_MASK) != GTE_OPCODE)
					apply_exception(r, CAUSE_INTERRUPT, 1'b0, 1'b0, it);
			end
			KIND_RAISE: begin
				apply_exception(r, {1'b0, it.cause_value}, it.in_delay_slot, it.cop_vector, it);
			end
			default: begin
			end
		endcase
		r.fired_events = fired;
		r.next_due = ev_earliest;
		return r;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.kind = 2'($urandom_range(0, 3));
		it.event_index = 4'($urandom_range(0, 15));
		it.time_value = {$urandom, $urandom};
		it.irq_status = 11'($urandom);
		it.irq_mask = 11'($urandom);
		it.current_status = $urandom;
		it.current_pc = $urandom;
		it.next_instruction = $urandom;
		it.cause_value = 31'($urandom);
		it.in_delay_slot = 1'($urandom_range(0, 1));
		it.cop_vector = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = tx_steady ? 0 : int'($urandom_range(0, 12));
		if ($urandom_range(0, 15) == 0)
			tx_steady = !tx_steady;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_bus <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		outcome_fifo[exp_wr_ptr] = compute_outcome(it);
		exp_wr_ptr = exp_wr_ptr + 4'd1;
		items_sent++;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (exp_wr_ptr != exp_rd_ptr)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (exp_wr_ptr == exp_rd_ptr) begin
					$display("%0t ns: result with nothing expected, actual %h", $time, result_bus);
					mismatches++;
				end else begin
					want = outcome_fifo[exp_rd_ptr];
					exp_rd_ptr = exp_rd_ptr + 4'd1;
					check_field("fired_events", 64'(want.fired_events),
						64'(result_bus.fired_events));
					check_field("exception_taken", 64'(want.exception_taken),
						64'(result_bus.exception_taken));
					check_field("new_pc", 64'(want.new_pc), 64'(result_bus.new_pc));
					check_field("new_epc", 64'(want.new_epc), 64'(result_bus.new_epc));
					check_field("new_cause", 64'(want.new_cause), 64'(result_bus.new_cause));
					check_field("new_status", 64'(want.new_status),
						64'(result_bus.new_status));
					check_field("next_due", want.next_due, result_bus.next_due);
					results_checked++;
					if (want.fired_events != '0)
						fired_results++;
					if (want.exception_taken)
						taken_results++;
				end
				if ($urandom_range(0, 15) == 0)
					rx_steady = !rx_steady;
				rx_hold = rx_steady ? 0 : int'($urandom_range(0, 12));
			end
			if (rx_hold > 0) begin
				result_stall <= 1'b1;
				rx_hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic schedule_event(input logic [3:0] idx, input logic [63:0] target);
		item_t it;
		it = noise_item();
		it.kind = KIND_SCHEDULE;
		it.event_index = idx;
		it.time_value = target;
		send_item(it);
	endtask

	task automatic test_at(input logic [63:0] now);
		item_t it;
		it = noise_item();
		it.kind = KIND_TEST;
		it.time_value = now;
		send_item(it);
	endtask

	task automatic irq_probe(input logic [31:0] status, input logic [31:0] word,
			input logic [10:0] istat, input logic [10:0] imask);
		item_t it;
		it = noise_item();
		it.kind = KIND_TEST;
		it.time_value = '0;
		it.current_status = status;
		it.next_instruction = word;
		it.irq_status = istat;
		it.irq_mask = imask;
		send_item(it);
	endtask

	task automatic raise_exception(input logic [30:0] cause, input logic bd, input logic cop,
			input logic [31:0] status, input logic [31:0] pc);
		item_t it;
		it = noise_item();
		it.kind = KIND_RAISE;
		it.cause_value = cause;
		it.in_delay_slot = bd;
		it.cop_vector = cop;
		it.current_status = status;
		it.current_pc = pc;
		send_item(it);
	endtask

	// Walks retirement, the equal-time boundary, signed wrap of the distance,
	// ignored indexes, the unused kind and the largest positive distance.
	task automatic test_event_retire();
		item_t it;
		test_at(64'd0);
		schedule_event(4'd5, 64'd50);
		schedule_event(4'd0, 64'd100);
		schedule_event(4'd12, '1);
		schedule_event(4'd13, 64'd10);
		schedule_event(4'd15, 64'd20);
		it = noise_item();
		it.kind = KIND_UNUSED;
		send_item(it);
		test_at(64'd0);
		test_at(64'd60);
		test_at(64'd100);
		test_at(64'd101);
		schedule_event(4'd1, 64'd200);
		schedule_event(4'd2, 64'd200);
		schedule_event(4'd3, 64'd150);
		test_at(64'd120);
		test_at(64'd151);
		schedule_event(4'd4, 64'd201 + DIST_MAX);
		test_at(64'd201);
		test_at(64'd202);
	endtask

	task automatic test_interrupt_gate();
		irq_probe(STATUS_IE_IM2 | STATUS_BEV_MASK, 32'h4800_0000, '1, '1);
		irq_probe(STATUS_IE_IM2, {GTE_OPCODE, 24'h00_0000}, '1, '1);
		irq_probe(STATUS_IE_IM2, {GTE_OPCODE | 8'h01, 24'hff_ffff}, '1, '1);
		irq_probe(32'h0000_0400, 32'h0, '1, '1);
		irq_probe(STATUS_IE_IM2, 32'h0, 11'h555, 11'h2aa);
		irq_probe(~STATUS_BEV_MASK, '1, 11'h400, 11'h7ff);
	endtask

	task automatic test_exception_entry();
		raise_exception(31'h0000_0024, 1'b1, 1'b1, STATUS_BEV_MASK | 32'h0000_000f, 32'h0);
		raise_exception('1, 1'b0, 1'b0, 32'h0, '1);
		raise_exception('0, 1'b1, 1'b0, '1, 32'h8000_0004);
		raise_exception(31'h0000_002c, 1'b0, 1'b1, 32'h0000_0035, 32'h1234_5678);
	endtask

	// Mostly schedules near a running cycle count and tests as it advances, with
	// interrupts often enabled; the rest is unconstrained noise.
	task automatic test_random_traffic(input logic [63:0] base, input int count);
		item_t       it;
		logic [63:0] now;
		int          pick;
		now = base;
		for (int n = 0; n < count; n++) begin
			it = noise_item();
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				it.kind = KIND_SCHEDULE;
				it.event_index = 4'($urandom_range(0, NUM_EV - 1));
				if ($urandom_range(0, 9) == 0)
					it.time_value = now - 64'($urandom_range(0, 50));
				else
					it.time_value = now + 64'($urandom_range(1, 400));
			end else if (pick < 75) begin
				it.kind = KIND_TEST;
				now = now + 64'($urandom_range(0, 120));
				it.time_value = now;
				if ($urandom_range(0, 1) == 1)
					it.current_status = it.current_status | STATUS_IE_IM2;
				if ($urandom_range(0, 3) == 0)
					it.next_instruction[31:25] = GTE_OPCODE[7:1];
			end else if (pick < 88) begin
				it.kind = KIND_RAISE;
			end
			send_item(it);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_event_retire();
		test_interrupt_gate();
		test_exception_entry();
		wait_drained();
		test_random_traffic(64'd0, 130);
		wait_drained();
		test_random_traffic({$urandom, $urandom}, 130);
		wait_drained();
		test_random_traffic(64'hffff_ffff_ffff_ff00, 130);
		wait_drained();
		test_random_traffic(64'h7fff_ffff_ffff_ff00, 130);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (exp_wr_ptr != exp_rd_ptr) begin
			$display("%0t ns: %0d expected results never arrived", $time,
				4'(exp_wr_ptr - exp_rd_ptr));
			mismatches++;
		end
		$display("Directed scheduler, interrupt and exception checks plus four random phases.");
		$display("%0d items sent, %0d results checked, %0d with retired events, %0d with entry.",
			items_sent, results_checked, fired_results, taken_results);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
